// ===== rtl/fm_patch_capture_dedup_core_assert.svh =====
// ----------------------------------------------------------------------------
// fm patch capture assertion macros
// clocked assertion wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef FM_PATCH_CAPTURE_DEDUP_CORE_ASSERT_SVH
`define FM_PATCH_CAPTURE_DEDUP_CORE_ASSERT_SVH

// checked only while out of reset
`define FPCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FPCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fpcd_pkg.sv =====
// ----------------------------------------------------------------------------
// fm patch capture package
// patch record layout, codes and field decode shared by the block
// ----------------------------------------------------------------------------
`default_nettype none

package fpcd_pkg;

  localparam int TABLE_SLOTS_DEF  = 256;
  localparam int NUM_CHANNELS_DEF = 3;

  // packed patch record: four operators of 43 bits, then algorithm and feedback
  localparam int OP_BITS    = 43;
  localparam int PATCH_BITS = 178;

  localparam int AR_POS  = 0;
  localparam int DR_POS  = 5;
  localparam int SR_POS  = 10;
  localparam int RR_POS  = 15;
  localparam int SL_POS  = 19;
  localparam int TL_POS  = 23;
  localparam int KS_POS  = 30;
  localparam int ML_POS  = 32;
  localparam int DT_POS  = 36;
  localparam int SSG_POS = 39;
  localparam int AL_POS  = 172;
  localparam int FB_POS  = 175;

  typedef logic [PATCH_BITS-1:0] patch_t;

  localparam logic [7:0] KEY_ADDR = 8'h28;

  // result status codes
  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_NO_EVENT = 3'd1;
  localparam logic [2:0] ST_NEW      = 3'd2;
  localparam logic [2:0] ST_SWITCH   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_EMIT
  } fsm_state_t;

  // operator slot order by address bits 3..2
  localparam logic [1:0] SLOT_ORDER [4] = '{2'd0, 2'd2, 2'd1, 2'd3};

  // address selects a patch field (channel checks are done by the caller)
  function automatic logic field_hit(logic [7:0] a);
    logic hit;
    hit = (a[7:4] inside {[4'h3:4'h9]}) || ((a[7:4] == 4'hb) && (a[3:2] == 2'd0));
    return hit;
  endfunction

  function automatic patch_t apply_write(patch_t p, logic [7:0] a, logic [7:0] d);
    patch_t     q;
    logic [7:0] base;
    q    = p;
    base = 8'(OP_BITS * int'(SLOT_ORDER[a[3:2]]));
    case (a[7:4])
      4'h3: begin
        q[base + ML_POS +: 4] = d[3:0];
        q[base + DT_POS +: 3] = d[6:4];
      end
      4'h4: q[base + TL_POS +: 7] = d[6:0];
      4'h5: begin
        q[base + KS_POS +: 2] = d[7:6];
        q[base + AR_POS +: 5] = d[4:0];
      end
      4'h6: q[base + DR_POS +: 5] = d[4:0];
      4'h7: q[base + SR_POS +: 5] = d[4:0];
      4'h8: begin
        q[base + SL_POS +: 4] = d[7:4];
        q[base + RR_POS +: 4] = d[3:0];
      end
      4'h9: q[base + SSG_POS +: 4] = d[3:0];
      4'hb: begin
        if (a[3:2] == 2'd0) begin
          q[FB_POS +: 3] = d[5:3];
          q[AL_POS +: 3] = d[2:0];
        end
      end
      default: ;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fpcd_if.sv =====
// ----------------------------------------------------------------------------
// fm patch capture channel interfaces
// valid/ready channels for register writes and capture results
// ----------------------------------------------------------------------------
`default_nettype none

interface fpcd_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_addr;
  logic [7:0] reg_data;

  modport source (output valid, output reg_addr, output reg_data, input ready);
  modport sink   (input valid, input reg_addr, input reg_data, output ready);
endinterface

interface fpcd_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [1:0] channel;
  logic [7:0] patch_index;

  modport source (output valid, output status, output channel, output patch_index,
                  input ready);
  modport sink   (input valid, input status, input channel, input patch_index,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/fpcd_patch_ram.sv =====
// ----------------------------------------------------------------------------
// fm patch capture table ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fpcd_patch_ram #(
  parameter int DEPTH = fpcd_pkg::TABLE_SLOTS_DEF
) (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire  [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire  fpcd_pkg::patch_t     wr_data,
  input  wire                        rd_en,
  input  wire  [$clog2(DEPTH)-1:0]   rd_addr,
  output fpcd_pkg::patch_t           rd_data
);

  fpcd_pkg::patch_t mem [DEPTH];
  fpcd_pkg::patch_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/fm_patch_capture_dedup_core.sv =====
// ----------------------------------------------------------------------------
// fm patch capture with de-duplication
// per-channel patch capture and key-on lookup in a patch table ram
// ----------------------------------------------------------------------------
// Each accepted register write yields exactly one result transfer. Operator
// and algorithm/feedback writes update the addressed channel's patch record
// and mark it changed. A key-on write (0x28, upper nibble nonzero) to a
// changed channel scans the patch table ram one entry per cycle through its
// single read port; an unknown patch is appended and reported as new, a known
// one that differs from the channel's current patch as a switch. An empty
// table takes the first patch without a scan, and a full one reports full.
// The block holds one write at a time: it accepts it, executes it, scans the
// table when a key-on needs a lookup, then loads the result. The input is taken
// again while the result register still waits on the sink. The table needs no
// clearing pass after reset: a fill count marks which entries hold patches,
// and only those are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_patch_capture_dedup_core #(
  parameter int TABLE_SLOTS  = fpcd_pkg::TABLE_SLOTS_DEF,
  parameter int NUM_CHANNELS = fpcd_pkg::NUM_CHANNELS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  fpcd_req_if.sink          in_ch,
  fpcd_rsp_if.source        out_ch
);

  localparam int IDX_W    = $clog2(TABLE_SLOTS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CNT_W-1:0] FULL_COUNT  = CNT_W'(TABLE_SLOTS);
  localparam logic [1:0]       NUM_CH_CODE = 2'(NUM_CHANNELS);

  // control state
  fpcd_pkg::fsm_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     scan_r, scan_nxt;

  // per-channel state
  fpcd_pkg::patch_t          patch_r   [NUM_CHANNELS];
  fpcd_pkg::patch_t          patch_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]   changed_r, changed_nxt;
  logic [NUM_CHANNELS-1:0]   cur_valid_r, cur_valid_nxt;
  logic [IDX_W-1:0]          cur_idx_r   [NUM_CHANNELS];
  logic [IDX_W-1:0]          cur_idx_nxt [NUM_CHANNELS];

  // latched write and pending result
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [2:0]       res_status_r, res_status_nxt;
  logic [1:0]       res_ch_r, res_ch_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;

  // output register
  logic [2:0] out_status_r, out_status_nxt;
  logic [1:0] out_channel_r, out_channel_nxt;
  logic [7:0] out_index_r, out_index_nxt;

  // table ram port
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  fpcd_pkg::patch_t ram_rd_data;
  fpcd_pkg::patch_t key_patch;

  // decode of the latched write
  logic                in_xfer;
  logic                out_free;
  logic                slot3;
  logic                is_key;
  logic [1:0]          key_ch;
  logic                key_ok;
  logic [CH_IDX_W-1:0] kx;
  logic [CH_IDX_W-1:0] cx;
  logic                wr_ok;
  logic                key_event;
  logic                tbl_full;
  logic                tbl_empty;
  logic                hit;
  logic                last_entry;
  logic                cur_same;
  logic [IDX_W+7:0]    idx_wide;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign slot3  = (addr_r[1:0] == 2'd3);
  assign is_key = (addr_r == fpcd_pkg::KEY_ADDR);
  assign key_ch = data_r[1:0];
  assign key_ok = (key_ch < NUM_CH_CODE);
  assign kx     = key_ch[CH_IDX_W-1:0];
  assign cx     = addr_r[CH_IDX_W-1:0];
  // plain field write to an existing channel
  assign wr_ok  = !slot3 && !is_key && (addr_r[1:0] < NUM_CH_CODE);

  // key-on that needs a table lookup (or reports a full table)
  assign key_event = !slot3 && is_key && key_ok && changed_r[kx] && (data_r[7:4] != 4'd0);
  assign tbl_full  = (count_r == FULL_COUNT);
  assign tbl_empty = (count_r == '0);

  // scan compare against the registered ram word
  assign key_patch  = patch_r[kx];
  assign hit        = (ram_rd_data == key_patch);
  assign last_entry = ((CNT_W'(scan_r) + CNT_W'(1)) == count_r);
  assign cur_same   = cur_valid_r[kx] && (cur_idx_r[kx] == scan_r);

  assign idx_wide = (IDX_W + 8)'(res_idx_r);

  // handshake and payload out
  assign in_ch.ready        = (state_r == fpcd_pkg::S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.channel     = out_channel_r;
  assign out_ch.patch_index = out_index_r;

  fpcd_patch_ram #(
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (key_patch),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpcd_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = fpcd_pkg::S_EXEC;
        end
      end
      fpcd_pkg::S_EXEC: begin
        if (key_event && !tbl_full && !tbl_empty) begin
          state_nxt = fpcd_pkg::S_SEARCH;
        end else begin
          state_nxt = fpcd_pkg::S_EMIT;
        end
      end
      fpcd_pkg::S_SEARCH: begin
        if (hit || last_entry) begin
          state_nxt = fpcd_pkg::S_EMIT;
        end
      end
      fpcd_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = fpcd_pkg::S_IDLE;
        end
      end
      default: state_nxt = fpcd_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control per state
  always_comb begin
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    patch_nxt      = patch_r;
    changed_nxt    = changed_r;
    cur_valid_nxt  = cur_valid_r;
    cur_idx_nxt    = cur_idx_r;
    res_status_nxt = res_status_r;
    res_ch_nxt     = res_ch_r;
    res_idx_nxt    = res_idx_r;
    addr_nxt       = addr_r;
    data_nxt       = data_r;
    // result leaves the output register on its transfer
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_channel_nxt = out_channel_r;
    out_index_nxt   = out_index_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = count_r[IDX_W-1:0];
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;

    case (state_r)
      fpcd_pkg::S_IDLE: begin
        if (in_xfer) begin
          addr_nxt = in_ch.reg_addr;
          data_nxt = in_ch.reg_data;
        end
      end

      fpcd_pkg::S_EXEC: begin
        res_status_nxt = fpcd_pkg::ST_IGNORED;
        res_ch_nxt     = 2'd0;
        res_idx_nxt    = '0;
        if (!slot3 && is_key && key_ok) begin
          res_ch_nxt     = key_ch;
          res_status_nxt = fpcd_pkg::ST_NO_EVENT;
          if (key_event) begin
            if (tbl_full) begin
              res_status_nxt  = fpcd_pkg::ST_FULL;
              changed_nxt[kx] = 1'b0;
            end else if (tbl_empty) begin
              // first patch goes straight into entry zero
              ram_wr_en          = 1'b1;
              count_nxt          = count_r + CNT_W'(1);
              cur_valid_nxt[kx]  = 1'b1;
              cur_idx_nxt[kx]    = '0;
              res_status_nxt     = fpcd_pkg::ST_NEW;
              changed_nxt[kx]    = 1'b0;
            end else begin
              // fetch entry zero, compare next cycle
              ram_rd_en   = 1'b1;
              ram_rd_addr = '0;
              scan_nxt    = '0;
            end
          end
        end else if (wr_ok) begin
          res_ch_nxt     = addr_r[1:0];
          res_status_nxt = fpcd_pkg::ST_NO_EVENT;
          if (fpcd_pkg::field_hit(addr_r)) begin
            patch_nxt[cx]   = fpcd_pkg::apply_write(patch_r[cx], addr_r, data_r);
            changed_nxt[cx] = 1'b1;
          end
        end
      end

      fpcd_pkg::S_SEARCH: begin
        if (hit) begin
          changed_nxt[kx] = 1'b0;
          if (!cur_same) begin
            cur_valid_nxt[kx] = 1'b1;
            cur_idx_nxt[kx]   = scan_r;
            res_status_nxt    = fpcd_pkg::ST_SWITCH;
            res_idx_nxt       = scan_r;
          end
        end else if (last_entry) begin
          // no match: append behind the last stored patch
          ram_wr_en         = 1'b1;
          count_nxt         = count_r + CNT_W'(1);
          cur_valid_nxt[kx] = 1'b1;
          cur_idx_nxt[kx]   = count_r[IDX_W-1:0];
          res_status_nxt    = fpcd_pkg::ST_NEW;
          res_idx_nxt       = count_r[IDX_W-1:0];
          changed_nxt[kx]   = 1'b0;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = scan_r + IDX_W'(1);
          scan_nxt    = scan_r + IDX_W'(1);
        end
      end

      fpcd_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_channel_nxt = res_ch_r;
          out_index_nxt   = idx_wide[7:0];
        end
      end

      default: ;
    endcase
  end

  // control and reset-defined state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpcd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      changed_r   <= '0;
      cur_valid_r <= '0;
      patch_r     <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      changed_r   <= changed_nxt;
      cur_valid_r <= cur_valid_nxt;
      patch_r     <= patch_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_r        <= scan_nxt;
    cur_idx_r     <= cur_idx_nxt;
    addr_r        <= addr_nxt;
    data_r        <= data_nxt;
    res_status_r  <= res_status_nxt;
    res_ch_r      <= res_ch_nxt;
    res_idx_r     <= res_idx_nxt;
    out_status_r  <= out_status_nxt;
    out_channel_r <= out_channel_nxt;
    out_index_r   <= out_index_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/fpcd_checker.sv =====
// ----------------------------------------------------------------------------
// fm patch capture port checker
// port-level assertions, bound to the core
// ----------------------------------------------------------------------------
`default_nettype none

`include "fm_patch_capture_dedup_core_assert.svh"

module fpcd_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [2:0] out_status,
  input wire [1:0] out_channel,
  input wire [7:0] out_patch_index
);

  // stalled result holds
  `FPCD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_channel) && $stable(out_patch_index), "stalled result changed")

  // one write in flight: ready drops after each input transfer
  `FPCD_ASSERT(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready, "input taken while busy")

  // only new and switch results carry an index
  `FPCD_ASSERT(a_idx_zero, clk, rst_n, out_valid && (out_status == fpcd_pkg::ST_IGNORED || out_status == fpcd_pkg::ST_NO_EVENT || out_status == fpcd_pkg::ST_FULL) |-> out_patch_index == 8'd0, "index on non-lookup result")

  // ignored writes report channel zero
  `FPCD_ASSERT(a_ign_ch, clk, rst_n, out_valid && out_status == fpcd_pkg::ST_IGNORED |-> out_channel == 2'd0, "ignored write with channel")

  // reset empties the result register
  `FPCD_ASSERT_ALWAYS(a_rst_out, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind fm_patch_capture_dedup_core fpcd_checker u_fpcd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_channel     (out_ch.channel),
  .out_patch_index (out_ch.patch_index)
);

`default_nettype wire
